// ===== rtl/pat_pkg.sv =====
// Shared types and constants for the program association section parser.
// No dependencies; every other file of the block but pat_if imports this package.
`default_nettype none
package pat_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [2:0] KIND_PROGRAM  = 3'd0;
  localparam logic [2:0] KIND_NETWORK  = 3'd1;
  localparam logic [2:0] KIND_DONE     = 3'd2;
  localparam logic [2:0] KIND_DUP      = 3'd3;
  localparam logic [2:0] KIND_BAD_TID  = 3'd4;
  localparam logic [2:0] KIND_BAD_BITS = 3'd5;
  localparam logic [2:0] KIND_BAD_LEN  = 3'd6;

  localparam logic [7:0]  TID_FORBIDDEN = 8'hFF;
  localparam logic [11:0] LEN_RSV_MASK  = 12'hC00;
  localparam logic [11:0] LEN_MAX       = 12'h3FD;
  localparam logic [11:0] LEN_MIN       = 12'd9;
  localparam logic [9:0]  LEN_OVERHEAD  = 10'd6;
  localparam logic [9:0]  ENTRY_BASE    = 10'd8;
  localparam logic [9:0]  CRC_TAIL      = 10'd3;

  localparam logic [9:0] POS_LEN_HI  = 10'd1;
  localparam logic [9:0] POS_LEN_LO  = 10'd2;
  localparam logic [9:0] POS_TSID_HI = 10'd3;
  localparam logic [9:0] POS_TSID_LO = 10'd4;
  localparam logic [9:0] POS_VERSION = 10'd5;
  localparam logic [9:0] POS_SECTION = 10'd6;
  localparam logic [9:0] POS_LAST    = 10'd7;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [15:0] program_number;
    logic [12:0] pid;
    logic [15:0] stream_id;
    logic [4:0]  version;
    logic        current_next;
    logic [7:0]  section_number;
    logic [7:0]  last_section;
  } pat_result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pat_q_status_t;

endpackage
`default_nettype wire

// ===== rtl/pat_if.sv =====
// Valid/ready channel interfaces for section bytes in and parse results out.
// Standalone; used by the top level and its environment.
`default_nettype none
interface pat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       section_start;

  modport source (output valid, output data_byte, output section_start, input ready);
  modport sink   (input valid, input data_byte, input section_start, output ready);
endinterface

interface pat_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [15:0] program_number;
  logic [12:0] pid;
  logic [15:0] stream_id;
  logic [4:0]  version;
  logic        current_next;
  logic [7:0]  section_number;
  logic [7:0]  last_section;

  modport source (output valid, output result_kind, output program_number, output pid,
                  output stream_id, output version, output current_next,
                  output section_number, output last_section, input ready);
  modport sink   (input valid, input result_kind, input program_number, input pid,
                  input stream_id, input version, input current_next,
                  input section_number, input last_section, output ready);
endinterface
`default_nettype wire

// ===== rtl/pat_section_parser_top.sv =====
// Top level of the program association section parser.
// Depends on pat_pkg, pat_if, pat_front, pat_queue and pat_back.
//
// Usage:
//   in_bus carries one section byte per beat with section_start marking the
//   table id byte. A start beat always opens a new section and drops any
//   section in progress; bytes outside a section are consumed silently.
//   out_bus carries at most one result per input beat: a program entry or
//   network PID on the fourth byte of each entry, a done result on the fourth
//   CRC byte, or one error/duplicate result on the last section number
//   byte, along with the current header fields.
//   Throughput is one byte per cycle while the result queue is not full. A result
//   passes through the queue write and then the output register to out_bus.
//   in_bus.ready drops only while the result queue is full, which happens
//   when the receiver holds out_bus.ready low; bytes keep flowing until then.
//   Reset (rst_n low, synchronous) clears the parser state, the recorded
//   section number and the queue; the block then waits for a start beat.
`default_nettype none
module pat_section_parser_top import pat_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pat_in_if.sink    in_bus,
  pat_out_if.source out_bus
);

  logic          accept;
  logic          push;
  logic          pop;
  pat_result_t   push_data;
  pat_result_t   q_data;
  pat_result_t   out_data;
  pat_q_status_t q_status;

  assign in_bus.ready = !q_status.full;
  assign accept       = in_bus.valid && in_bus.ready;

  pat_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_bus.data_byte),
    .section_start (in_bus.section_start),
    .push          (push),
    .push_data     (push_data)
  );

  pat_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .status    (q_status)
  );

  pat_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_data  (out_data)
  );

  assign out_bus.result_kind    = out_data.result_kind;
  assign out_bus.program_number = out_data.program_number;
  assign out_bus.pid            = out_data.pid;
  assign out_bus.stream_id      = out_data.stream_id;
  assign out_bus.version        = out_data.version;
  assign out_bus.current_next   = out_data.current_next;
  assign out_bus.section_number = out_data.section_number;
  assign out_bus.last_section   = out_data.last_section;

endmodule
`default_nettype wire

// ===== rtl/pat_front.sv =====
// Front end: byte-position tracking, header latch, header checks, entry assembly.
// Depends on pat_pkg; pushes one result per qualifying beat into the queue.
`default_nettype none
module pat_front import pat_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        section_start,
  output logic             push,
  output pat_result_t      push_data
);

  logic [9:0]  pos_r, pos_nxt;
  logic        active_r, active_nxt;
  logic [11:0] len_r, len_nxt;
  logic [7:0]  tid_r, tid_nxt;
  logic [15:0] tsid_r, tsid_nxt;
  logic [4:0]  ver_r, ver_nxt;
  logic        cur_r, cur_nxt;
  logic [7:0]  secn_r, secn_nxt;
  logic [7:0]  last_r, last_nxt;
  logic [7:0]  rec_sec_r, rec_sec_nxt;
  logic        rec_valid_r, rec_valid_nxt;
  logic [23:0] ent_r, ent_nxt;
  logic [9:0]  lim;
  logic [2:0]  kind;
  logic [15:0] pn;
  logic [12:0] pid;

  assign lim = ENTRY_BASE + ((len_r[9:0] - LEN_OVERHEAD) & ~10'd3);

  always_comb begin
    pos_nxt       = pos_r;
    active_nxt    = active_r;
    len_nxt       = len_r;
    tid_nxt       = tid_r;
    tsid_nxt      = tsid_r;
    ver_nxt       = ver_r;
    cur_nxt       = cur_r;
    secn_nxt      = secn_r;
    last_nxt      = last_r;
    rec_sec_nxt   = rec_sec_r;
    rec_valid_nxt = rec_valid_r;
    ent_nxt       = ent_r;
    push          = 1'b0;
    kind          = KIND_PROGRAM;
    pn            = 16'd0;
    pid           = 13'd0;
    if (accept) begin
      if (section_start) begin
        tid_nxt    = data_byte;
        pos_nxt    = POS_LEN_HI;
        active_nxt = 1'b1;
      end else if (active_r) begin
        pos_nxt = pos_r + 10'd1;
        case (pos_r)
          POS_LEN_HI:  len_nxt = {data_byte[3:0], 8'h00};
          POS_LEN_LO:  len_nxt = {len_r[11:8], data_byte};
          POS_TSID_HI: tsid_nxt = {data_byte, 8'h00};
          POS_TSID_LO: tsid_nxt = {tsid_r[15:8], data_byte};
          POS_VERSION: begin
            ver_nxt = data_byte[5:1];
            cur_nxt = data_byte[0];
          end
          POS_SECTION: secn_nxt = data_byte;
          POS_LAST: begin
            last_nxt   = data_byte;
            active_nxt = 1'b0;
            push       = 1'b1;
            if (rec_valid_r && rec_sec_r == secn_r) begin
              kind = KIND_DUP;
            end else begin
              rec_sec_nxt   = secn_r;
              rec_valid_nxt = 1'b1;
              if (tid_r == TID_FORBIDDEN) begin
                kind = KIND_BAD_TID;
              end else if ((len_r & LEN_RSV_MASK) != 12'd0) begin
                kind = KIND_BAD_BITS;
              end else if (len_r >= LEN_MAX || len_r < LEN_MIN) begin
                kind = KIND_BAD_LEN;
              end else begin
                push       = 1'b0;
                active_nxt = 1'b1;
              end
            end
          end
          default: begin
            if (pos_r < ENTRY_BASE) begin
              active_nxt = 1'b0;
            end else if (pos_r < lim) begin
              if (pos_r[1:0] != 2'd3) begin
                ent_nxt = {ent_r[15:0], data_byte};
              end else begin
                push = 1'b1;
                pn   = ent_r[23:8];
                pid  = {ent_r[4:0], data_byte};
                kind = (ent_r[23:8] == 16'd0) ? KIND_NETWORK : KIND_PROGRAM;
              end
            end else if (pos_r >= lim + CRC_TAIL) begin
              active_nxt = 1'b0;
              push       = 1'b1;
              kind       = KIND_DONE;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    push_data.result_kind    = kind;
    push_data.program_number = pn;
    push_data.pid            = pid;
    push_data.stream_id      = tsid_nxt;
    push_data.version        = ver_nxt;
    push_data.current_next   = cur_nxt;
    push_data.section_number = secn_nxt;
    push_data.last_section   = last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 10'd0;
      active_r    <= 1'b0;
      len_r       <= 12'd0;
      tid_r       <= 8'd0;
      tsid_r      <= 16'd0;
      ver_r       <= 5'd0;
      cur_r       <= 1'b0;
      secn_r      <= 8'd0;
      last_r      <= 8'd0;
      rec_sec_r   <= 8'd0;
      rec_valid_r <= 1'b0;
      ent_r       <= 24'd0;
    end else begin
      pos_r       <= pos_nxt;
      active_r    <= active_nxt;
      len_r       <= len_nxt;
      tid_r       <= tid_nxt;
      tsid_r      <= tsid_nxt;
      ver_r       <= ver_nxt;
      cur_r       <= cur_nxt;
      secn_r      <= secn_nxt;
      last_r      <= last_nxt;
      rec_sec_r   <= rec_sec_nxt;
      rec_valid_r <= rec_valid_nxt;
      ent_r       <= ent_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pat_queue.sv =====
// Short result queue decoupling the parsing front end from the output stage.
// Depends on pat_pkg for the result type and status struct.
`default_nettype none
module pat_queue import pat_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire pat_result_t push_data,
  input  wire logic        pop,
  output pat_result_t      pop_data,
  output pat_q_status_t    status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  pat_result_t   mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign status.full  = (cnt_r == FULL_CNT);
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + PW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + PW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= FULL_CNT)
    else $error("queue count over depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && status.full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && status.empty))
    else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == FULL_CNT) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

// ===== rtl/pat_back.sv =====
// Back end: output register that drains the queue into the result channel.
// Depends on pat_pkg for the result type and queue status.
`default_nettype none
module pat_back import pat_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pat_q_status_t q_status,
  input  wire pat_result_t   q_data,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pat_result_t        out_data
);

  logic        vld_r, vld_nxt;
  pat_result_t data_r;

  assign pop       = !q_status.empty && (!vld_r || out_ready);
  assign vld_nxt   = pop || (vld_r && !out_ready);
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) data_r <= q_data;
  end

endmodule
`default_nettype wire

// ===== tb/pat_section_parser_top_test.sv =====
`timescale 1ns / 1ps
// Testbench for pat_section_parser_top: directed section table, then random sections.
// Results are checked against typed rows or the bench parser. Needs pat_pkg and pat_if.
module pat_section_parser_top_test;
  import pat_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_BYTES  = 100;
  localparam int IN_IDLE [4]   = '{0, 59, 0, 23};
  localparam int OUT_STALL [4] = '{0, 0, 59, 23};

  typedef struct packed {
    logic        start;
    logic [7:0]  data;
    logic        typed;
    pat_result_t res;
  } dir_row_t;

  localparam pat_result_t NO_RES = '0;
  localparam int DIR_N = 76;

  // typed rows carry the result that beat must produce
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    {1'b0, 8'hA5, 1'b0, NO_RES},
    // valid section, one network entry and one program entry at the extremes
    {1'b1, 8'h00, 1'b0, NO_RES}, {1'b0, 8'h00, 1'b0, NO_RES}, {1'b0, 8'h11, 1'b0, NO_RES},
    {1'b0, 8'hFF, 1'b0, NO_RES}, {1'b0, 8'hFF, 1'b0, NO_RES}, {1'b0, 8'hFF, 1'b0, NO_RES},
    {1'b0, 8'h00, 1'b0, NO_RES}, {1'b0, 8'hFF, 1'b0, NO_RES},
    {1'b0, 8'h00, 1'b0, NO_RES}, {1'b0, 8'h00, 1'b0, NO_RES}, {1'b0, 8'hFF, 1'b0, NO_RES},
    {1'b0, 8'hFF, 1'b0, NO_RES},
    {1'b0, 8'hFF, 1'b0, NO_RES}, {1'b0, 8'hFF, 1'b0, NO_RES}, {1'b0, 8'hE0, 1'b0, NO_RES},
    {1'b0, 8'h00, 1'b0, NO_RES},
    {1'b0, 8'h12, 1'b0, NO_RES}, {1'b0, 8'h34, 1'b0, NO_RES}, {1'b0, 8'h56, 1'b0, NO_RES},
    {1'b0, 8'h78, 1'b0, NO_RES},
    // repeated section number
    {1'b1, 8'h00, 1'b0, NO_RES}, {1'b0, 8'h00, 1'b0, NO_RES}, {1'b0, 8'h11, 1'b0, NO_RES},
    {1'b0, 8'h12, 1'b0, NO_RES}, {1'b0, 8'h34, 1'b0, NO_RES}, {1'b0, 8'h00, 1'b0, NO_RES},
    {1'b0, 8'h00, 1'b0, NO_RES},
    {1'b0, 8'h01, 1'b1, KIND_DUP, 16'h0, 13'h0, 16'h1234, 5'd0, 1'b0, 8'h00, 8'h01},
    // forbidden table id
    {1'b1, 8'hFF, 1'b0, NO_RES}, {1'b0, 8'h00, 1'b0, NO_RES}, {1'b0, 8'h0D, 1'b0, NO_RES},
    {1'b0, 8'h00, 1'b0, NO_RES}, {1'b0, 8'h00, 1'b0, NO_RES}, {1'b0, 8'h3E, 1'b0, NO_RES},
    {1'b0, 8'h01, 1'b0, NO_RES},
    {1'b0, 8'h01, 1'b1, KIND_BAD_TID, 16'h0, 13'h0, 16'h0000, 5'd31, 1'b0, 8'h01, 8'h01},
    // restart mid-section, then reserved length bits
    {1'b1, 8'h00, 1'b0, NO_RES}, {1'b0, 8'h00, 1'b0, NO_RES}, {1'b1, 8'h00, 1'b0, NO_RES},
    {1'b0, 8'h0C, 1'b0, NO_RES}, {1'b0, 8'h00, 1'b0, NO_RES}, {1'b0, 8'h00, 1'b0, NO_RES},
    {1'b0, 8'h01, 1'b0, NO_RES}, {1'b0, 8'h01, 1'b0, NO_RES}, {1'b0, 8'h02, 1'b0, NO_RES},
    {1'b0, 8'h02, 1'b1, KIND_BAD_BITS, 16'h0, 13'h0, 16'h0001, 5'd0, 1'b1, 8'h02, 8'h02},
    // stray byte while waiting
    {1'b0, 8'h55, 1'b0, NO_RES},
    // length 0x3fd
    {1'b1, 8'h00, 1'b0, NO_RES}, {1'b0, 8'hF3, 1'b0, NO_RES}, {1'b0, 8'hFD, 1'b0, NO_RES},
    {1'b0, 8'hAB, 1'b0, NO_RES}, {1'b0, 8'hCD, 1'b0, NO_RES}, {1'b0, 8'h02, 1'b0, NO_RES},
    {1'b0, 8'h03, 1'b0, NO_RES},
    {1'b0, 8'h03, 1'b1, KIND_BAD_LEN, 16'h0, 13'h0, 16'hABCD, 5'd1, 1'b0, 8'h03, 8'h03},
    // length 8
    {1'b1, 8'h00, 1'b0, NO_RES}, {1'b0, 8'h00, 1'b0, NO_RES}, {1'b0, 8'h08, 1'b0, NO_RES},
    {1'b0, 8'h00, 1'b0, NO_RES}, {1'b0, 8'h00, 1'b0, NO_RES}, {1'b0, 8'h00, 1'b0, NO_RES},
    {1'b0, 8'h04, 1'b0, NO_RES},
    {1'b0, 8'h04, 1'b1, KIND_BAD_LEN, 16'h0, 13'h0, 16'h0000, 5'd0, 1'b0, 8'h04, 8'h04},
    // length 9: no entries, CRC only
    {1'b1, 8'h00, 1'b0, NO_RES}, {1'b0, 8'h00, 1'b0, NO_RES}, {1'b0, 8'h09, 1'b0, NO_RES},
    {1'b0, 8'h00, 1'b0, NO_RES}, {1'b0, 8'h07, 1'b0, NO_RES}, {1'b0, 8'hC1, 1'b0, NO_RES},
    {1'b0, 8'h05, 1'b0, NO_RES}, {1'b0, 8'h05, 1'b0, NO_RES},
    {1'b0, 8'hDE, 1'b0, NO_RES}, {1'b0, 8'hAD, 1'b0, NO_RES}, {1'b0, 8'hBE, 1'b0, NO_RES},
    {1'b0, 8'hEF, 1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst_n;

  pat_in_if  in_bus ();
  pat_out_if out_bus ();

  pat_section_parser_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  always #10 clk = ~clk;

  // section parser state
  logic [9:0]  sec_pos    = '0;
  logic        sec_active = 1'b0;
  logic [11:0] sec_len    = '0;
  logic [7:0]  sec_tid    = '0;
  logic [15:0] hdr_tsid   = '0;
  logic [4:0]  hdr_ver    = '0;
  logic        hdr_cur    = 1'b0;
  logic [7:0]  hdr_sec    = '0;
  logic [7:0]  hdr_last   = '0;
  logic [7:0]  seen_sec   = '0;
  logic        seen_ok    = 1'b0;
  logic [23:0] entry_acc  = '0;

  pat_result_t due_results [$];
  int          n_err = 0;
  int          cycle_n = 0;
  int          fed_count = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  bit          beat_typed = 1'b0;
  pat_result_t beat_res = '0;
  logic [7:0]  gen_last_sec = 8'h05;

  function automatic pat_result_t make_result(input logic [2:0] kind, input logic [15:0] pn,
                                              input logic [12:0] pid);
    pat_result_t r;
    r.result_kind    = kind;
    r.program_number = pn;
    r.pid            = pid;
    r.stream_id      = hdr_tsid;
    r.version        = hdr_ver;
    r.current_next   = hdr_cur;
    r.section_number = hdr_sec;
    r.last_section   = hdr_last;
    return r;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic st,
                                    output pat_result_t r);
    int pos;
    int off;
    int span;
    logic [15:0] pn;
    r = '0;
    if (st) begin
      sec_tid    = b;
      sec_pos    = 10'd1;
      sec_active = 1'b1;
      return 1'b0;
    end
    if (!sec_active) return 1'b0;
    pos = sec_pos;
    sec_pos = sec_pos + 10'd1;
    case (pos)
      1: sec_len = {b[3:0], 8'h00};
      2: sec_len[7:0] = b;
      3: hdr_tsid = {b, 8'h00};
      4: hdr_tsid[7:0] = b;
      5: begin
        hdr_ver = b[5:1];
        hdr_cur = b[0];
      end
      6: hdr_sec = b;
      default: ;
    endcase
    if (pos == 7) begin
      hdr_last   = b;
      sec_active = 1'b0;
      if (seen_ok && seen_sec == hdr_sec) begin
        r = make_result(KIND_DUP, 16'h0, 13'h0);
        return 1'b1;
      end
      seen_sec = hdr_sec;
      seen_ok  = 1'b1;
      if (sec_tid == 8'hFF) r = make_result(KIND_BAD_TID, 16'h0, 13'h0);
      else if (sec_len[11:10] != 2'b00) r = make_result(KIND_BAD_BITS, 16'h0, 13'h0);
      else if (sec_len >= 12'h3FD || sec_len < 12'd9) r = make_result(KIND_BAD_LEN, 16'h0, 13'h0);
      else begin
        sec_active = 1'b1;
        return 1'b0;
      end
      return 1'b1;
    end
    if (pos < 8) return 1'b0;
    off  = pos - 8;
    span = ((int'(sec_len) - 6) / 4) * 4;
    if (off < span) begin
      if (off % 4 != 3) begin
        entry_acc = {entry_acc[15:0], b};
        return 1'b0;
      end
      pn = entry_acc[23:8];
      r = make_result((pn == 16'h0) ? KIND_NETWORK : KIND_PROGRAM, pn, {entry_acc[4:0], b});
      return 1'b1;
    end
    if (off - span >= 3) begin
      sec_active = 1'b0;
      r = make_result(KIND_DONE, 16'h0, 13'h0);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report(input string what, input longint got_v, input longint exp_v);
    n_err++;
    if (n_err <= 40)
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got_v, exp_v, cycle_n);
  endtask

  task automatic check_result(input pat_result_t got, input pat_result_t exp);
    if (got.result_kind !== exp.result_kind)
      report("result_kind", got.result_kind, exp.result_kind);
    if (got.program_number !== exp.program_number)
      report("program_number", got.program_number, exp.program_number);
    if (got.pid !== exp.pid) report("pid", got.pid, exp.pid);
    if (got.stream_id !== exp.stream_id) report("stream_id", got.stream_id, exp.stream_id);
    if (got.version !== exp.version) report("version", got.version, exp.version);
    if (got.current_next !== exp.current_next)
      report("current_next", got.current_next, exp.current_next);
    if (got.section_number !== exp.section_number)
      report("section_number", got.section_number, exp.section_number);
    if (got.last_section !== exp.last_section)
      report("last_section", got.last_section, exp.last_section);
  endtask

  always @(posedge clk) begin
    pat_result_t pred;
    pat_result_t got;
    bit hit;
    cycle_n++;
    if (cycle_n > LIMIT_CYCLES) begin
      $display("[pat_section_parser_top] ERROR");
      $finish;
    end
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        if (in_bus.section_start || sec_active) fed_count++;
        hit = parse_byte(in_bus.data_byte, in_bus.section_start, pred);
        if (beat_typed) due_results.push_back(beat_res);
        else if (hit) due_results.push_back(pred);
      end
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.result_kind, out_bus.program_number, out_bus.pid, out_bus.stream_id,
               out_bus.version, out_bus.current_next, out_bus.section_number,
               out_bus.last_section};
        if (due_results.size() == 0) report("unexpected result, kind", got.result_kind, 0);
        else check_result(got, due_results.pop_front());
      end
    end
  end

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready = ($urandom_range(99) >= out_stall_pct);
    end
  end

  task automatic put_byte(input logic [7:0] d, input logic st, input bit typed,
                          input pat_result_t r);
    while ($urandom_range(99) < in_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid         = 1'b1;
    in_bus.data_byte     = d;
    in_bus.section_start = st;
    beat_typed           = typed;
    beat_res             = r;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic send_section(input bit longest);
    logic [7:0]  tid;
    logic [7:0]  sec;
    logic [7:0]  b;
    logic [11:0] len;
    int roll;
    int n_ent;
    int total;
    int cut;
    int i;
    bit zero_pn;
    roll = $urandom_range(99);
    tid = (roll < 5) ? 8'hFF : (roll < 15) ? 8'($urandom) : 8'h00;
    roll = $urandom_range(99);
    if (longest) len = 12'h3FC;
    else if (roll < 3) len = 12'($urandom_range(0, 8));
    else if (roll < 5) len = 12'($urandom_range(12'h3FD, 12'h3FF));
    else if (roll < 8) len = 12'($urandom_range(12'h400, 12'hFFF));
    else if (roll < 9) len = 12'($urandom_range(12'h40, 12'h120));
    else len = 12'($urandom_range(9, 36));
    sec = ($urandom_range(9) == 0) ? gen_last_sec : 8'($urandom);
    gen_last_sec = sec;
    n_ent = (len >= 12'd9 && len < 12'h3FD) ? (int'(len) - 6) / 4 : 0;
    total = (len >= 12'd9 && len < 12'h3FD) ? 12 + 4 * n_ent : 8;
    cut = ($urandom_range(19) == 0) ? $urandom_range(1, total - 1) : total;
    zero_pn = 1'b0;
    for (i = 0; i < cut; i++) begin
      case (i)
        0: b = tid;
        1: b = {4'($urandom), len[11:8]};
        2: b = len[7:0];
        6: b = sec;
        default: b = 8'($urandom);
      endcase
      if (i >= 8 && i < 8 + 4 * n_ent) begin
        if ((i - 8) % 4 == 0) zero_pn = ($urandom_range(4) == 0);
        if ((i - 8) % 4 < 2 && zero_pn) b = 8'h00;
      end
      put_byte(b, i == 0, 1'b0, NO_RES);
    end
    if ($urandom_range(4) == 0)
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom), 1'b0, 1'b0, NO_RES);
  endtask

  initial begin
    int goal;
    bit first;
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.data_byte     = 8'h00;
    in_bus.section_start = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int k = 0; k < DIR_N; k++)
      put_byte(DIR_TAB[k].data, DIR_TAB[k].start, DIR_TAB[k].typed, DIR_TAB[k].res);
    in_bus.valid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct   = IN_IDLE[ph];
      out_stall_pct = OUT_STALL[ph];
      goal  = fed_count + PHASE_BYTES;
      first = (ph == 0);
      while (fed_count < goal) begin
        send_section(first);
        first = 1'b0;
      end
      // hold the sender until the parser has drained
      in_bus.valid = 1'b0;
      while (due_results.size() != 0) @(negedge clk);
    end

    out_stall_pct = 0;
    repeat (8) @(negedge clk);
    if (n_err == 0) begin
      $display("[pat_section_parser_top] OK");
    end else begin
      $display("[pat_section_parser_top] ERROR");
    end
    $finish;
  end

endmodule
